[rtl/mrt_pkg.sv]
`default_nettype none

package mrt_pkg;

    localparam int DEFAULT_DEPTH = 64;

    localparam int HANDLE_W = 16;
    localparam int BASE_W   = 48;
    localparam int LEN_W    = 31;
    localparam int END_W    = BASE_W + 1;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 96;

    typedef logic [OP_W-1:0]     t_op;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_op OP_INSERT          = 3'd0;
    localparam t_op OP_REMOVE          = 3'd1;
    localparam t_op OP_FIND_CONTAINING = 3'd2;
    localparam t_op OP_FIND_EXACT      = 3'd3;
    localparam t_op OP_CLEAR           = 3'd4;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_NOT_FOUND = 2'd1;
    localparam t_status ST_FULL      = 2'd2;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [BASE_W-1:0]   base;
        logic [LEN_W-1:0]    len;
    } t_entry;

    // request held steady for the whole scan
    typedef struct packed {
        t_op                 op;
        logic [HANDLE_W-1:0] handle;
        logic [BASE_W-1:0]   base;
        logic [LEN_W-1:0]    len;
        logic [END_W-1:0]    req_end;
    } t_req;

    // scan token passed from cell to cell
    typedef struct packed {
        logic   valid;
        logic   found;
        t_entry ent;
    } t_wave;

    typedef struct packed {
        logic   en;
        t_entry ent;
    } t_wr;

endpackage

`default_nettype wire

[rtl/memory_region_table.sv]
// Memory region table: holds up to TABLE_DEPTH regions (handle, base, length)
// in a row of cells, one entry per cell, kept dense at indices below the entry
// count. A request word carries the operation in tuser and handle, base and
// length in tdata; each request yields exactly one result word with a status
// in tuser (0 ok or found, 1 not found, 2 full) and the matched entry in
// tdata, zero unless a find hits. Insert, clear and the undefined codes reach
// the result register via the done state. Remove, find-containing and
// find-exact launch a scan token into cell 0 that advances one cell per cycle;
// each cell checks its own entry, and the first hit in index order is carried
// to the end, so the scan passes every cell regardless of where the hit
// lies. Remove writes the last entry into the freed slot when it completes.
// One request is in flight at a time; the result register lets the next
// request be accepted while the previous result waits. Codes 5 to 7 report
// not found and leave the table alone. Entries are not cleared at reset; only
// the count.
`default_nettype none

module memory_region_table #(
    parameter int TABLE_DEPTH = mrt_pkg::DEFAULT_DEPTH
) (
    input  wire  logic                        i_clk,
    input  wire  logic                        i_rst_n,
    input  wire  logic                        i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // handle [15:0], base_address [63:16], length [94:64], zero [95]
    input  wire  logic [mrt_pkg::DATA_W-1:0]  i_s_axis_tdata,
    // operation [2:0]
    input  wire  logic [mrt_pkg::OP_W-1:0]    i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  wire  logic                        i_m_axis_tready,
    // found_handle [15:0], found_base [63:16], found_length [94:64], zero [95]
    output logic [mrt_pkg::DATA_W-1:0]        o_m_axis_tdata,
    // status [1:0]
    output logic [mrt_pkg::STATUS_W-1:0]      o_m_axis_tuser
);
    import mrt_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state             r_state;
    t_req               r_req;
    logic               r_launch;
    logic [CNT_W-1:0]   r_count;
    logic               r_found;
    logic [IDX_W-1:0]   r_found_idx;
    t_entry             r_found_ent;
    logic               r_out_valid;
    t_status            r_out_status;
    t_entry             r_out_ent;

    t_wave              wave     [TABLE_DEPTH+1];
    logic [IDX_W-1:0]   wave_idx [TABLE_DEPTH+1];
    t_wr                wr;
    logic [IDX_W-1:0]   wr_idx;

    logic               in_accept;
    logic               in_scan_op;
    logic               out_free;
    logic               commit;
    logic               full;
    t_status            res_status;
    t_entry             res_ent;
    t_entry             in_ent;

    assign in_ent.handle = i_s_axis_tdata[15:0];
    assign in_ent.base   = i_s_axis_tdata[63:16];
    assign in_ent.len    = i_s_axis_tdata[94:64];

    assign o_s_axis_tready = r_state == S_IDLE;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign in_scan_op      = i_s_axis_tuser == OP_REMOVE ||
                             i_s_axis_tuser == OP_FIND_CONTAINING ||
                             i_s_axis_tuser == OP_FIND_EXACT;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign commit          = r_state == S_DONE && out_free;
    assign full            = r_count == CNT_W'(TABLE_DEPTH);

    // Launch the token into cell 0 for one cycle
    always_comb begin
        wave[0].valid = r_launch;
        wave[0].found = 1'b0;
        wave[0].ent   = '0;
        wave_idx[0]   = '0;
    end

    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        mrt_cell #(
            .CELL_INDEX (k),
            .IDX_W      (IDX_W),
            .CNT_W      (CNT_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_req      (r_req),
            .i_count    (r_count),
            .i_wave     (wave[k]),
            .i_wave_idx (wave_idx[k]),
            .i_wr       (wr),
            .i_wr_idx   (wr_idx),
            .o_wave     (wave[k+1]),
            .o_wave_idx (wave_idx[k+1])
        );
    end

    // Result of the finished request and the table write it implies
    always_comb begin
        res_status = ST_OK;
        res_ent    = '0;
        wr.en      = 1'b0;
        wr.ent     = r_found_ent;
        wr_idx     = r_found_idx;
        case (r_req.op)
            OP_INSERT: begin
                if (full) begin
                    res_status = ST_FULL;
                end else begin
                    wr.en        = commit;
                    wr.ent.handle = r_req.handle;
                    wr.ent.base   = r_req.base;
                    wr.ent.len    = r_req.len;
                    wr_idx        = r_count[IDX_W-1:0];
                end
            end
            OP_REMOVE: begin
                if (r_found) begin
                    wr.en = commit;
                end else begin
                    res_status = ST_NOT_FOUND;
                end
            end
            OP_FIND_CONTAINING, OP_FIND_EXACT: begin
                if (r_found) begin
                    res_ent = r_found_ent;
                end else begin
                    res_status = ST_NOT_FOUND;
                end
            end
            OP_CLEAR: res_status = ST_OK;
            default:  res_status = ST_NOT_FOUND;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_launch    <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_launch <= in_accept && in_scan_op;
            // load a new result word, or drop the one just taken
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        if (in_scan_op) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SCAN: begin
                    // token leaves the last cell: scan complete
                    if (wave[TABLE_DEPTH].valid) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                        case (r_req.op)
                            OP_INSERT: begin
                                if (!full) begin
                                    r_count <= r_count + CNT_W'(1);
                                end
                            end
                            OP_REMOVE: begin
                                if (r_found) begin
                                    r_count <= r_count - CNT_W'(1);
                                end
                            end
                            OP_CLEAR: r_count <= '0;
                            default:  r_count <= r_count;
                        endcase
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Payload registers: hold request, scan result and output word
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req.op      <= i_s_axis_tuser;
            r_req.handle  <= in_ent.handle;
            r_req.base    <= in_ent.base;
            r_req.len     <= in_ent.len;
            r_req.req_end <= {1'b0, in_ent.base} + END_W'(in_ent.len);
            r_found       <= 1'b0;
        end else if (r_state == S_SCAN && wave[TABLE_DEPTH].valid) begin
            r_found     <= wave[TABLE_DEPTH].found;
            r_found_idx <= wave_idx[TABLE_DEPTH];
            r_found_ent <= wave[TABLE_DEPTH].ent;
        end
        if (commit) begin
            r_out_status <= res_status;
            r_out_ent    <= res_ent;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {1'b0, r_out_ent.len, r_out_ent.base, r_out_ent.handle};

endmodule

`default_nettype wire

[rtl/mrt_cell.sv]
`default_nettype none

module mrt_cell #(
    parameter int CELL_INDEX = 0,
    parameter int IDX_W      = 6,
    parameter int CNT_W      = 7
) (
    input  wire  logic               i_clk,
    input  wire  logic               i_rst_n,
    input  wire  mrt_pkg::t_req      i_req,
    input  wire  logic [CNT_W-1:0]   i_count,
    input  wire  mrt_pkg::t_wave     i_wave,
    input  wire  logic [IDX_W-1:0]   i_wave_idx,
    input  wire  mrt_pkg::t_wr       i_wr,
    input  wire  logic [IDX_W-1:0]   i_wr_idx,
    output mrt_pkg::t_wave           o_wave,
    output logic [IDX_W-1:0]         o_wave_idx
);
    import mrt_pkg::*;

    t_entry             r_ent;
    t_wave              r_wave;
    t_wave              n_wave;
    logic [IDX_W-1:0]   r_wave_idx;
    logic [IDX_W-1:0]   n_wave_idx;
    logic               in_use;
    logic               is_last;
    logic [END_W-1:0]   ent_end;
    logic               hit;

    assign in_use  = CNT_W'(CELL_INDEX) < i_count;
    assign is_last = CNT_W'(CELL_INDEX + 1) == i_count;
    assign ent_end = {1'b0, r_ent.base} + END_W'(r_ent.len);

    always_comb begin
        case (i_req.op)
            OP_REMOVE:          hit = r_ent.handle == i_req.handle;
            OP_FIND_CONTAINING: hit = (r_ent.base <= i_req.base) && (ent_end >= i_req.req_end);
            OP_FIND_EXACT:      hit = (r_ent.base == i_req.base) && (r_ent.len == i_req.len);
            default:            hit = 1'b0;
        endcase
    end

    always_comb begin
        n_wave     = i_wave;
        n_wave_idx = i_wave_idx;
        if (i_wave.valid) begin
            if (!i_wave.found && in_use && hit) begin
                n_wave.found = 1'b1;
                n_wave_idx   = IDX_W'(CELL_INDEX);
                // a find returns this entry; a remove carries the last entry instead
                if (i_req.op != OP_REMOVE) begin
                    n_wave.ent = r_ent;
                end
            end
            if (i_req.op == OP_REMOVE && is_last) begin
                n_wave.ent = r_ent;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave.valid <= 1'b0;
        end else begin
            r_wave.valid <= n_wave.valid;
        end
        r_wave.found <= n_wave.found;
        r_wave.ent   <= n_wave.ent;
        r_wave_idx   <= n_wave_idx;
        if (i_wr.en && i_wr_idx == IDX_W'(CELL_INDEX)) begin
            r_ent <= i_wr.ent;
        end
    end

    assign o_wave     = r_wave;
    assign o_wave_idx = r_wave_idx;

endmodule

`default_nettype wire

[rtl/mrt_checker.sv]
`default_nettype none

module mrt_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_s_axis_tvalid,
    input wire logic                        i_s_axis_tready,
    input wire logic                        i_m_axis_tvalid,
    input wire logic                        i_m_axis_tready,
    input wire logic [mrt_pkg::DATA_W-1:0]  i_m_axis_tdata,
    input wire logic [mrt_pkg::STATUS_W-1:0] i_m_axis_tuser
);
    import mrt_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && !i_m_axis_tready |=>
            i_m_axis_tvalid && $stable(i_m_axis_tdata) && $stable(i_m_axis_tuser))
        else $error("result word changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid |-> (i_m_axis_tuser == ST_OK || i_m_axis_tuser == ST_NOT_FOUND ||
                             i_m_axis_tuser == ST_FULL))
        else $error("undefined status code");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && i_m_axis_tuser != ST_OK |-> i_m_axis_tdata == '0)
        else $error("nonzero entry with a failing status");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && i_s_axis_tready |=> !i_s_axis_tready)
        else $error("request accepted while another is in flight");

endmodule

bind memory_region_table mrt_checker u_mrt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .i_s_axis_tready (o_s_axis_tready),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire
